@@ rtl/mavt_pkg.sv @@
package mavt_pkg;

    localparam int CPR_W   = 16;
    localparam int TURN_W  = 32;
    localparam int FA_W    = 48;
    localparam int VEL_W   = 32;
    localparam int HALF_W  = 24;
    localparam int PROD_W  = FA_W + HALF_W;
    localparam int DIV_W   = 23;
    localparam int QUO_W   = VEL_W + 1;
    localparam int DIV_STEPS = PROD_W / 2;
    localparam int STEP_W  = $clog2(DIV_STEPS);

    localparam logic [CPR_W-1:0]  CPR_RESET    = 16'd32768;
    localparam logic [HALF_W-1:0] TICK_RATE    = 24'd9000000;
    localparam logic [DIV_W-1:0]  TICK_LIMIT   = 23'd4500000;
    localparam logic [DIV_W-1:0]  TICK_DEFAULT = 23'd9000;
    localparam logic [VEL_W-1:0]  VEL_POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0]  VEL_NEG_MAX  = 32'h8000_0000;

    typedef struct packed {
        logic load;
        logic turn;
        logic prod;
        logic angle;
        logic diff;
        logic mag;
        logic mlo;
        logic mhi;
        logic msum;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic op;
    } t_stat;

endpackage

@@ rtl/multiturn_angle_velocity_tracker.sv @@
// Channel     | Direction | Contents
// s_axis      | in        | tdata: raw_angle, timer_now; tuser: operation
// m_axis      | out       | tdata: turns, full_angle, velocity;
//             |           | tuser: velocity_valid, velocity_saturated
// cfg         | in        | data: counts_per_rev
//
// One item is in work at a time; the input is ready again once the finished
// word has gone into the output register. Operation 1 adds the 72-bit by
// 23-bit division of the velocity, two quotient bits per cycle, which makes
// it the longer operation.
// A finished word waits in the output register while the next word is taken.
// Reset is synchronous and active low; it clears the turn count and the
// velocity reference and sets counts_per_rev to 32768.
module multiturn_angle_velocity_tracker #(
    parameter int ANGLE_BITS = 15,
    parameter int TIMER_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // raw_angle, timer_now, zero padding
    input  logic [((ANGLE_BITS+TIMER_BITS+7)/8)*8-1:0] s_axis_tdata,
    // operation
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // turns, full_angle, velocity
    output logic [mavt_pkg::TURN_W+mavt_pkg::FA_W+mavt_pkg::VEL_W-1:0] m_axis_tdata,
    // velocity_valid, velocity_saturated
    output logic [1:0]                        m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mavt_pkg::CPR_W-1:0]        i_cfg_data
);

    mavt_pkg::t_cmd                       cmd;
    mavt_pkg::t_stat                      stat;
    logic signed [mavt_pkg::TURN_W-1:0]   turns;
    logic signed [mavt_pkg::FA_W-1:0]     full_angle;
    logic signed [mavt_pkg::VEL_W-1:0]    velocity;
    logic                                 velocity_valid;
    logic                                 velocity_saturated;

    assign o_cfg_ready = 1'b1;

    mavt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    mavt_dp #(
        .ANGLE_BITS (ANGLE_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_data           (i_cfg_data),
        .i_op                 (s_axis_tuser),
        .i_raw_angle          (s_axis_tdata[ANGLE_BITS-1:0]),
        .i_timer_now          (s_axis_tdata[ANGLE_BITS+TIMER_BITS-1:ANGLE_BITS]),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .o_turns              (turns),
        .o_full_angle         (full_angle),
        .o_velocity           (velocity),
        .o_velocity_valid     (velocity_valid),
        .o_velocity_saturated (velocity_saturated)
    );

    assign m_axis_tdata = {velocity, full_angle, turns};
    assign m_axis_tuser = {velocity_saturated, velocity_valid};

endmodule

@@ rtl/mavt_ctrl.sv @@
module mavt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output mavt_pkg::t_cmd  o_cmd,
    input  mavt_pkg::t_stat i_stat
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_TURN  = 11'b000_0000_0010,
        S_PROD  = 11'b000_0000_0100,
        S_ANGLE = 11'b000_0000_1000,
        S_DIFF  = 11'b000_0001_0000,
        S_MAG   = 11'b000_0010_0000,
        S_MLO   = 11'b000_0100_0000,
        S_MHI   = 11'b000_1000_0000,
        S_MSUM  = 11'b001_0000_0000,
        S_DIV   = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    t_state                         r_state, n_state;
    logic [mavt_pkg::STEP_W-1:0]    r_step, n_step;
    logic                           r_out_valid, n_out_valid;
    logic                           out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TURN;
                end
            end
            S_TURN: begin
                o_cmd.turn = 1'b1;
                n_state    = S_PROD;
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_ANGLE;
            end
            S_ANGLE: begin
                o_cmd.angle = 1'b1;
                n_state     = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = i_stat.op ? S_MAG : S_DONE;
            end
            S_MAG: begin
                o_cmd.mag = 1'b1;
                n_state   = S_MLO;
            end
            S_MLO: begin
                o_cmd.mlo = 1'b1;
                n_state   = S_MHI;
            end
            S_MHI: begin
                o_cmd.mhi = 1'b1;
                n_state   = S_MSUM;
            end
            S_MSUM: begin
                o_cmd.msum = 1'b1;
                n_step     = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == mavt_pkg::STEP_W'(mavt_pkg::DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/mavt_dp.sv @@
module mavt_dp #(
    parameter int ANGLE_BITS = 15,
    parameter int TIMER_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [mavt_pkg::CPR_W-1:0]        i_cfg_data,
    input  logic                              i_op,
    input  logic [ANGLE_BITS-1:0]             i_raw_angle,
    input  logic [TIMER_BITS-1:0]             i_timer_now,
    input  mavt_pkg::t_cmd                    i_cmd,
    output mavt_pkg::t_stat                   o_stat,
    output logic signed [mavt_pkg::TURN_W-1:0] o_turns,
    output logic signed [mavt_pkg::FA_W-1:0]  o_full_angle,
    output logic signed [mavt_pkg::VEL_W-1:0] o_velocity,
    output logic                              o_velocity_valid,
    output logic                              o_velocity_saturated
);

    localparam int CPR_W  = mavt_pkg::CPR_W;
    localparam int TURN_W = mavt_pkg::TURN_W;
    localparam int FA_W   = mavt_pkg::FA_W;
    localparam int VEL_W  = mavt_pkg::VEL_W;
    localparam int HALF_W = mavt_pkg::HALF_W;
    localparam int PROD_W = mavt_pkg::PROD_W;
    localparam int DIV_W  = mavt_pkg::DIV_W;
    localparam int QUO_W  = mavt_pkg::QUO_W;
    localparam int CMP_W  = (ANGLE_BITS + 3 > CPR_W + 2) ? ANGLE_BITS + 3 : CPR_W + 2;
    localparam int TK_W   = (TIMER_BITS + 1 > DIV_W) ? TIMER_BITS + 1 : DIV_W;

    logic [CPR_W-1:0]       r_cpr;
    logic                   r_op;
    logic [ANGLE_BITS-1:0]  r_raw;
    logic [TIMER_BITS-1:0]  r_now;
    logic [TURN_W-1:0]      r_turns;
    logic [ANGLE_BITS-1:0]  r_prev_raw;
    logic                   r_seeded;
    logic [TIMER_BITS-1:0]  r_prev_ts;
    logic [FA_W-1:0]        r_prev_fa;
    logic [FA_W-1:0]        r_prod;
    logic [FA_W-1:0]        r_fa;
    logic [FA_W-1:0]        r_diff;
    logic [DIV_W-1:0]       r_ticks;
    logic [FA_W-1:0]        r_dmag;
    logic                   r_neg;
    logic [2*HALF_W-1:0]    r_plo;
    logic [2*HALF_W-1:0]    r_phi;
    logic [PROD_W-1:0]      r_dvd;
    logic [DIV_W-1:0]       r_rem;
    logic [QUO_W-1:0]       r_quo;
    logic                   r_ovf;
    logic [TURN_W-1:0]      r_o_turns;
    logic [FA_W-1:0]        r_o_fa;
    logic [VEL_W-1:0]       r_o_vel;
    logic                   r_o_vvalid;
    logic                   r_o_sat;

    logic [ANGLE_BITS-1:0]          mag;
    logic [CMP_W-1:0]               mag5;
    logic [CMP_W-1:0]               cpr4;
    logic                           wrap;
    logic signed [TURN_W+CPR_W:0]   prod_full;
    logic [TIMER_BITS-1:0]          now_inv;
    logic [TK_W-1:0]                ticks_raw;
    logic                           ticks_odd;
    logic [DIV_W-1:0]               ticks_sel;
    logic [HALF_W-1:0]              mul_a;
    logic [2*HALF_W-1:0]            mul_out;
    logic [DIV_W:0]                 t1, t2;
    logic                           ge1, ge2;
    logic [DIV_W:0]                 d1, d2;
    logic [DIV_W-1:0]               rem1, rem2;
    logic                           pos_sat, neg_sat;
    logic [VEL_W-1:0]               vel_mag;

    assign o_stat.op = r_op;

    assign mag  = (r_raw > r_prev_raw) ? (r_raw - r_prev_raw) : (r_prev_raw - r_raw);
    assign mag5 = CMP_W'({mag, 2'b00}) + CMP_W'(mag);
    assign cpr4 = CMP_W'({r_cpr, 2'b00});
    assign wrap = mag5 > cpr4;

    assign prod_full = $signed(r_turns) * $signed({1'b0, r_cpr});

    assign now_inv   = ~r_now;
    assign ticks_raw = (r_now < r_prev_ts) ? TK_W'(r_prev_ts - r_now)
                                           : TK_W'(now_inv) + TK_W'(r_prev_ts);
    assign ticks_odd = (ticks_raw == '0) || (ticks_raw > TK_W'(mavt_pkg::TICK_LIMIT));
    assign ticks_sel = ticks_odd ? mavt_pkg::TICK_DEFAULT : ticks_raw[DIV_W-1:0];

    assign mul_a   = i_cmd.mhi ? r_dmag[FA_W-1:HALF_W] : r_dmag[HALF_W-1:0];
    assign mul_out = (2*HALF_W)'(mul_a) * (2*HALF_W)'(mavt_pkg::TICK_RATE);

    assign t1   = {r_rem, r_dvd[PROD_W-1]};
    assign ge1  = t1 >= {1'b0, r_ticks};
    assign d1   = t1 - {1'b0, r_ticks};
    assign rem1 = ge1 ? d1[DIV_W-1:0] : t1[DIV_W-1:0];
    assign t2   = {rem1, r_dvd[PROD_W-2]};
    assign ge2  = t2 >= {1'b0, r_ticks};
    assign d2   = t2 - {1'b0, r_ticks};
    assign rem2 = ge2 ? d2[DIV_W-1:0] : t2[DIV_W-1:0];

    assign pos_sat = r_ovf || r_quo[QUO_W-1] || r_quo[VEL_W-1];
    assign neg_sat = r_ovf || r_quo[QUO_W-1] || (r_quo[VEL_W-1] && (r_quo[VEL_W-2:0] != '0));
    assign vel_mag = r_quo[VEL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr      <= mavt_pkg::CPR_RESET;
            r_turns    <= '0;
            r_prev_raw <= '0;
            r_seeded   <= 1'b0;
            r_prev_ts  <= '0;
            r_prev_fa  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cpr <= i_cfg_data;
            end
            if (i_cmd.turn) begin
                if (!r_seeded) begin
                    r_seeded <= 1'b1;
                end else if (wrap) begin
                    r_turns <= (r_raw > r_prev_raw) ? r_turns - 1'b1 : r_turns + 1'b1;
                end
                r_prev_raw <= r_raw;
            end
            if (i_cmd.diff && r_op) begin
                r_prev_fa <= r_fa;
                r_prev_ts <= r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_raw <= i_raw_angle;
            r_now <= i_timer_now;
        end
        if (i_cmd.prod) begin
            r_prod <= prod_full[FA_W-1:0];
        end
        if (i_cmd.angle) begin
            r_fa <= r_prod + FA_W'(r_raw);
        end
        if (i_cmd.diff) begin
            r_diff  <= r_fa - r_prev_fa;
            r_ticks <= ticks_sel;
        end
        if (i_cmd.mag) begin
            r_neg  <= r_diff[FA_W-1];
            r_dmag <= r_diff[FA_W-1] ? (~r_diff + 1'b1) : r_diff;
        end
        if (i_cmd.mlo) begin
            r_plo <= mul_out;
        end
        if (i_cmd.mhi) begin
            r_phi <= mul_out;
        end
        if (i_cmd.msum) begin
            r_dvd <= {r_phi, {HALF_W{1'b0}}} + PROD_W'(r_plo);
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[PROD_W-3:0], 2'b00};
            r_rem <= rem2;
            r_quo <= {r_quo[QUO_W-3:0], ge1, ge2};
            r_ovf <= r_ovf || r_quo[QUO_W-1] || r_quo[QUO_W-2];
        end
        if (i_cmd.out_load) begin
            r_o_turns <= r_turns;
            r_o_fa    <= r_fa;
            if (r_op) begin
                r_o_vvalid <= 1'b1;
                if (r_neg) begin
                    r_o_sat <= neg_sat;
                    r_o_vel <= neg_sat ? mavt_pkg::VEL_NEG_MAX : (~vel_mag + 1'b1);
                end else begin
                    r_o_sat <= pos_sat;
                    r_o_vel <= pos_sat ? mavt_pkg::VEL_POS_MAX : vel_mag;
                end
            end else begin
                r_o_vvalid <= 1'b0;
                r_o_sat    <= 1'b0;
                r_o_vel    <= '0;
            end
        end
    end

    assign o_turns              = r_o_turns;
    assign o_full_angle         = r_o_fa;
    assign o_velocity           = r_o_vel;
    assign o_velocity_valid     = r_o_vvalid;
    assign o_velocity_saturated = r_o_sat;

endmodule

@@ rtl/mavt_chk.sv @@
module mavt_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Output word dropped while stalled.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input taken while a word is in work.");

    a_no_velocity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            (m_axis_tdata[111:80] == 32'h0) && !m_axis_tuser[1])
        else $error("Velocity or saturation reported without a velocity read.");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            (m_axis_tdata[111:80] == 32'h7FFF_FFFF) ||
            (m_axis_tdata[111:80] == 32'h8000_0000))
        else $error("Saturated velocity is not a range limit.");

endmodule

bind multiturn_angle_velocity_tracker mavt_chk u_mavt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
